### rtl/core/kl_pkg.sv
// Package: shared types, codes and constants of the keyword lexer.
`timescale 1ns / 1ps
package kl_pkg;

	localparam int TEXT_LEN   = 32;
	localparam int CNT_W      = $clog2(TEXT_LEN + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_NUM   = 3'd1,
		MODE_WORD  = 3'd2,
		MODE_STR   = 3'd3,
		MODE_ESC   = 3'd4,
		MODE_COLON = 3'd5
	} mode_t;

	localparam logic [4:0] KIND_END    = 5'd0;
	localparam logic [4:0] KIND_NUM    = 5'd1;
	localparam logic [4:0] KIND_IDENT  = 5'd2;
	localparam logic [4:0] KIND_STR    = 5'd3;
	localparam logic [4:0] KIND_LET    = 5'd4;
	localparam logic [4:0] KIND_FUNC   = 5'd5;
	localparam logic [4:0] KIND_IF     = 5'd6;
	localparam logic [4:0] KIND_ELSE   = 5'd7;
	localparam logic [4:0] KIND_IS     = 5'd8;
	localparam logic [4:0] KIND_CREATE = 5'd9;
	localparam logic [4:0] KIND_PLUS   = 5'd10;
	localparam logic [4:0] KIND_MINUS  = 5'd11;
	localparam logic [4:0] KIND_STAR   = 5'd12;
	localparam logic [4:0] KIND_SLASH  = 5'd13;
	localparam logic [4:0] KIND_PCT    = 5'd14;
	localparam logic [4:0] KIND_LT     = 5'd15;
	localparam logic [4:0] KIND_GT     = 5'd16;
	localparam logic [4:0] KIND_LPAREN = 5'd17;
	localparam logic [4:0] KIND_RPAREN = 5'd18;
	localparam logic [4:0] KIND_ASSIGN = 5'd19;
	localparam logic [4:0] KIND_SEMI   = 5'd20;
	localparam logic [4:0] KIND_LBRACK = 5'd21;
	localparam logic [4:0] KIND_RBRACK = 5'd22;
	localparam logic [4:0] KIND_TEXT   = 5'd23;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_ESCAPE  = 2'd1;
	localparam logic [1:0] ERR_UNTERM  = 2'd2;

	// Keyword spellings, right-aligned, first letter in the highest used byte
	localparam logic [63:0] KW_LET   = 64'h0000_0000_006C_6574;
	localparam logic [63:0] KW_FUNC  = 64'h6675_6E63_7469_6F6E;
	localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6966;
	localparam logic [63:0] KW_ELSE  = 64'h0000_0000_656C_7365;
	localparam logic [63:0] KW_IS    = 64'h0000_0000_0000_6973;
	localparam logic [63:0] KW_TRUE  = 64'h0000_0000_7472_7565;
	localparam logic [63:0] KW_FALSE = 64'h0000_0066_616C_7365;

	typedef struct packed {
		logic [4:0]         kind;
		logic signed [31:0] value;
		logic [1:0]         err;
	} res_t;

	typedef struct packed {
		mode_t              mode;
		logic [CNT_W-1:0]   count;
		logic [31:0]        accum;
		logic [63:0]        prefix;
	} lex_state_t;

endpackage

### rtl/core/kl_ifs.sv
// Interfaces: text byte channel and token channel of the keyword lexer.
`timescale 1ns / 1ps
interface kl_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface kl_token_if;
	logic               valid;
	logic               ready;
	logic [4:0]         token_kind;
	logic signed [31:0] token_value;
	logic [1:0]         lex_error;
	modport source(output valid, output token_kind, output token_value, output lex_error,
		input ready);
	modport sink(input valid, input token_kind, input token_value, input lex_error,
		output ready);
endinterface

### rtl/core/keyword_lexer.sv
// Top level: streaming keyword lexer, one text byte in, token results out.
//
// Usage:
//   text  - sink channel; one source byte per transfer, zero marks end of text.
//   token - source channel; one result (kind, value, error) per transfer.
//   A byte lands in an input register, then the combinational step logic updates
//   the lexer state and pushes zero, one or two results into a four-entry
//   result queue that drives the token channel.
// Path: a byte's result passes the input register and the result queue before
//   it shows on token, and waits there behind earlier queued results.
// Throughput: one byte per cycle, set by the step logic and the queue, as
//   long as the token side takes one result per cycle; a byte that closes a
//   token and starts another gives two results and needs two token transfers.
// Stall: the input register holds its byte while fewer than two queue entries
//   are free; text.ready drops only when that register is full and held.
// Reset: arst_n clears the queue, the input register and the lexer state,
//   which starts idle between tokens.
`timescale 1ns / 1ps
module keyword_lexer (
	input logic      clk,
	input logic      arst_n,
	kl_text_if.sink  text,
	kl_token_if.source token
);

	logic [7:0]                text_byte_s1;
	logic                      valid_s1;
	logic                      advance;
	kl_pkg::lex_state_t        state_q;
	kl_pkg::lex_state_t        state_d;
	kl_pkg::res_t              res0;
	kl_pkg::res_t              res1;
	kl_pkg::res_t              head;
	logic [1:0]                res_n;
	logic [kl_pkg::FCNT_W-1:0] fifo_count;
	logic                      pop;

	// Process the held byte only when the queue can take two results
	assign advance    = valid_s1 && fifo_count <= kl_pkg::FCNT_W'(kl_pkg::FIFO_DEPTH - 2);
	assign text.ready = !valid_s1 || advance;
	assign pop        = token.valid && token.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid)
			text_byte_s1 <= text.text_byte;
	end

	// Lexer state: advance once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: kl_pkg::MODE_IDLE, count: '0, accum: '0, prefix: '0};
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	kl_step u_step (
		.state_q   (state_q),
		.text_byte (text_byte_s1),
		.state_d   (state_d),
		.res0      (res0),
		.res1      (res1),
		.res_n     (res_n)
	);

	kl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (advance ? res_n : 2'd0),
		.res0   (res0),
		.res1   (res1),
		.pop    (pop),
		.head   (head),
		.count  (fifo_count)
	);

	assign token.valid       = fifo_count != '0;
	assign token.token_kind  = head.kind;
	assign token.token_value = head.value;
	assign token.lex_error   = head.err;

	// Queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= kl_pkg::FCNT_W'(kl_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// A held byte stays put until it is processed
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(text_byte_s1))
		else $error("input register lost a byte");

	// Lexer state moves only on a processed byte
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("lexer state changed without a byte");

endmodule

### rtl/core/kl_step.sv
// Step logic: next lexer state and up to two results for one text byte.
`timescale 1ns / 1ps
module kl_step (
	input  kl_pkg::lex_state_t state_q,
	input  logic [7:0]         text_byte,
	output kl_pkg::lex_state_t state_d,
	output kl_pkg::res_t       res0,
	output kl_pkg::res_t       res1,
	output logic [1:0]         res_n
);

	function automatic kl_pkg::res_t make_res(logic [4:0] kind, logic [31:0] value,
		logic [1:0] err);
		kl_pkg::res_t r;
		r.kind  = kind;
		r.value = value;
		r.err   = err;
		return r;
	endfunction

	function automatic logic [4:0] op_kind(logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h2B: k = kl_pkg::KIND_PLUS;
			8'h2D: k = kl_pkg::KIND_MINUS;
			8'h2A: k = kl_pkg::KIND_STAR;
			8'h2F: k = kl_pkg::KIND_SLASH;
			8'h25: k = kl_pkg::KIND_PCT;
			8'h3C: k = kl_pkg::KIND_LT;
			8'h3E: k = kl_pkg::KIND_GT;
			8'h28, 8'h7B: k = kl_pkg::KIND_LPAREN;
			8'h29, 8'h7D: k = kl_pkg::KIND_RPAREN;
			8'h3D: k = kl_pkg::KIND_ASSIGN;
			8'h3B: k = kl_pkg::KIND_SEMI;
			8'h5B: k = kl_pkg::KIND_LBRACK;
			8'h5D: k = kl_pkg::KIND_RBRACK;
			default: k = kl_pkg::KIND_END;
		endcase
		return k;
	endfunction

	// Close a word: keyword, true/false as a number, or plain identifier
	function automatic kl_pkg::res_t word_res(logic [kl_pkg::CNT_W-1:0] cnt,
		logic [63:0] pfx);
		kl_pkg::res_t r;
		if (cnt == kl_pkg::CNT_W'(3) && pfx == kl_pkg::KW_LET)
			r = make_res(kl_pkg::KIND_LET, 32'd0, kl_pkg::ERR_NONE);
		else if (cnt == kl_pkg::CNT_W'(8) && pfx == kl_pkg::KW_FUNC)
			r = make_res(kl_pkg::KIND_FUNC, 32'd0, kl_pkg::ERR_NONE);
		else if (cnt == kl_pkg::CNT_W'(2) && pfx == kl_pkg::KW_IF)
			r = make_res(kl_pkg::KIND_IF, 32'd0, kl_pkg::ERR_NONE);
		else if (cnt == kl_pkg::CNT_W'(4) && pfx == kl_pkg::KW_ELSE)
			r = make_res(kl_pkg::KIND_ELSE, 32'd0, kl_pkg::ERR_NONE);
		else if (cnt == kl_pkg::CNT_W'(2) && pfx == kl_pkg::KW_IS)
			r = make_res(kl_pkg::KIND_IS, 32'd0, kl_pkg::ERR_NONE);
		else if (cnt == kl_pkg::CNT_W'(4) && pfx == kl_pkg::KW_TRUE)
			r = make_res(kl_pkg::KIND_NUM, 32'd1, kl_pkg::ERR_NONE);
		else if (cnt == kl_pkg::CNT_W'(5) && pfx == kl_pkg::KW_FALSE)
			r = make_res(kl_pkg::KIND_NUM, 32'd0, kl_pkg::ERR_NONE);
		else
			r = make_res(kl_pkg::KIND_IDENT, 32'(cnt), kl_pkg::ERR_NONE);
		return r;
	endfunction

	logic         is_digit;
	logic         is_lower;
	logic         below_len;
	logic         room;
	logic [7:0]   mapped;
	logic [1:0]   map_err;
	kl_pkg::res_t res [2];

	assign is_digit  = text_byte >= 8'h30 && text_byte <= 8'h39;
	assign is_lower  = text_byte >= 8'h61 && text_byte <= 8'h7A;
	assign below_len = state_q.count < kl_pkg::CNT_W'(kl_pkg::TEXT_LEN);
	assign room      = state_q.count < kl_pkg::CNT_W'(kl_pkg::TEXT_LEN - 1);

	// Escape decode
	always_comb begin
		mapped  = text_byte;
		map_err = kl_pkg::ERR_NONE;
		case (text_byte)
			8'h6E: mapped = 8'h0A;
			8'h74: mapped = 8'h09;
			8'h72: mapped = 8'h0D;
			8'h5C, 8'h22, 8'h27: mapped = text_byte;
			default: map_err = kl_pkg::ERR_ESCAPE;
		endcase
	end

	always_comb begin
		logic do_idle;
		state_d = state_q;
		res[0]  = make_res(kl_pkg::KIND_END, 32'd0, kl_pkg::ERR_NONE);
		res[1]  = make_res(kl_pkg::KIND_END, 32'd0, kl_pkg::ERR_NONE);
		res_n   = 2'd0;
		do_idle = 1'b0;

		unique case (state_q.mode)
			kl_pkg::MODE_NUM: begin
				if (is_digit && below_len) begin
					state_d.accum = {state_q.accum[28:0], 3'b000}
						+ {state_q.accum[30:0], 1'b0} + {28'd0, text_byte[3:0]};
					state_d.count = state_q.count + kl_pkg::CNT_W'(1);
				end else begin
					res[0]  = make_res(kl_pkg::KIND_NUM, state_q.accum, kl_pkg::ERR_NONE);
					res_n   = 2'd1;
					do_idle = 1'b1;
				end
			end
			kl_pkg::MODE_WORD: begin
				if (is_lower && below_len) begin
					if (state_q.count < kl_pkg::CNT_W'(8))
						state_d.prefix = {state_q.prefix[55:0], text_byte};
					state_d.count = state_q.count + kl_pkg::CNT_W'(1);
					res[0] = make_res(kl_pkg::KIND_TEXT, 32'(text_byte), kl_pkg::ERR_NONE);
					res_n  = 2'd1;
				end else begin
					res[0]  = word_res(state_q.count, state_q.prefix);
					res_n   = 2'd1;
					do_idle = 1'b1;
				end
			end
			kl_pkg::MODE_STR, kl_pkg::MODE_ESC: begin
				if (text_byte == 8'h00) begin
					// unterminated string: close it flagged, then end the text
					state_d.mode = kl_pkg::MODE_IDLE;
					res[0] = make_res(kl_pkg::KIND_STR, 32'(state_q.count), kl_pkg::ERR_UNTERM);
					res_n  = 2'd2;
				end else if (state_q.mode == kl_pkg::MODE_STR && text_byte == 8'h22) begin
					state_d.mode = kl_pkg::MODE_IDLE;
					res[0] = make_res(kl_pkg::KIND_STR, 32'(state_q.count), kl_pkg::ERR_NONE);
					res_n  = 2'd1;
				end else if (state_q.mode == kl_pkg::MODE_STR && text_byte == 8'h5C) begin
					state_d.mode = kl_pkg::MODE_ESC;
				end else begin
					state_d.mode = kl_pkg::MODE_STR;
					if (room) begin
						state_d.count = state_q.count + kl_pkg::CNT_W'(1);
						if (state_q.mode == kl_pkg::MODE_ESC)
							res[0] = make_res(kl_pkg::KIND_TEXT, 32'(mapped), map_err);
						else
							res[0] = make_res(kl_pkg::KIND_TEXT, 32'(text_byte),
								kl_pkg::ERR_NONE);
						res_n = 2'd1;
					end
				end
			end
			kl_pkg::MODE_COLON: begin
				state_d.mode = kl_pkg::MODE_IDLE;
				if (text_byte == 8'h3D) begin
					res[0] = make_res(kl_pkg::KIND_CREATE, 32'd0, kl_pkg::ERR_NONE);
					res_n  = 2'd1;
				end else begin
					res[0]  = make_res(kl_pkg::KIND_END, 32'd0, kl_pkg::ERR_NONE);
					res_n   = 2'd1;
					do_idle = 1'b1;
				end
			end
			default: do_idle = 1'b1;
		endcase

		// Reprocess the byte between tokens
		if (do_idle) begin
			state_d.mode = kl_pkg::MODE_IDLE;
			if (text_byte == 8'h20 || text_byte == 8'h09 || text_byte == 8'h0A) begin
				state_d.mode = kl_pkg::MODE_IDLE;
			end else if (is_digit) begin
				state_d.mode  = kl_pkg::MODE_NUM;
				state_d.accum = {28'd0, text_byte[3:0]};
				state_d.count = kl_pkg::CNT_W'(1);
			end else if (is_lower) begin
				state_d.mode   = kl_pkg::MODE_WORD;
				state_d.prefix = 64'(text_byte);
				state_d.count  = kl_pkg::CNT_W'(1);
				res[res_n[0]]  = make_res(kl_pkg::KIND_TEXT, 32'(text_byte), kl_pkg::ERR_NONE);
				res_n          = res_n + 2'd1;
			end else if (text_byte == 8'h22) begin
				state_d.mode  = kl_pkg::MODE_STR;
				state_d.count = '0;
			end else if (text_byte == 8'h3A) begin
				state_d.mode = kl_pkg::MODE_COLON;
			end else begin
				res[res_n[0]] = make_res(op_kind(text_byte), 32'd0, kl_pkg::ERR_NONE);
				res_n         = res_n + 2'd1;
			end
		end
	end

	assign res0 = res[0];
	assign res1 = res[1];

endmodule

### rtl/core/kl_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
`timescale 1ns / 1ps
module kl_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                push_n,
	input  kl_pkg::res_t              res0,
	input  kl_pkg::res_t              res1,
	input  logic                      pop,
	output kl_pkg::res_t              head,
	output logic [kl_pkg::FCNT_W-1:0] count
);

	kl_pkg::res_t              mem [kl_pkg::FIFO_DEPTH];
	logic [kl_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [kl_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [kl_pkg::FCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_ptr_q] <= res0;
		if (push_n == 2'd2)
			mem[wr_ptr_q + kl_pkg::PTR_W'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + kl_pkg::PTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + kl_pkg::PTR_W'(1);
			count_q <= count_q + kl_pkg::FCNT_W'(push_n) - kl_pkg::FCNT_W'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign count = count_q;

endmodule

### tb/kl_checker.sv
// Checker: predicts the keyword lexer's tokens and compares them with the token channel.
`timescale 1ns / 1ps
module kl_checker
	import kl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	input  logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        token_valid,
	input  logic        token_ready,
	input  logic [4:0]  token_kind,
	input  logic [31:0] token_value,
	input  logic [1:0]  lex_error,
	output int          outstanding,
	output int          fail_count,
	output int          byte_count,
	output int          token_count
);

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_NUL = 8'h00;

	// Lexer state as the predictor sees it
	mode_t       mode;
	int          count;
	logic [31:0] accum;
	logic [63:0] prefix;
	res_t        token_queue[$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] token mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic push_token(input logic [4:0] kind, input logic [31:0] value,
		input logic [1:0] err);
		res_t tok;
		tok.kind  = kind;
		tok.value = value;
		tok.err   = err;
		token_queue.push_back(tok);
	endtask

	function automatic logic [4:0] operator_kind(input logic [7:0] c);
		case (c)
			"+":      return KIND_PLUS;
			"-":      return KIND_MINUS;
			"*":      return KIND_STAR;
			"/":      return KIND_SLASH;
			"%":      return KIND_PCT;
			"<":      return KIND_LT;
			">":      return KIND_GT;
			"(", "{": return KIND_LPAREN;
			")", "}": return KIND_RPAREN;
			"=":      return KIND_ASSIGN;
			";":      return KIND_SEMI;
			"[":      return KIND_LBRACK;
			"]":      return KIND_RBRACK;
			default:  return KIND_END;
		endcase
	endfunction

	// Close a word: keyword, true/false as numbers, else identifier with its length
	task automatic close_word();
		if (count == 3 && prefix == KW_LET) begin
			push_token(KIND_LET, '0, ERR_NONE);
		end else if (count == 8 && prefix == KW_FUNC) begin
			push_token(KIND_FUNC, '0, ERR_NONE);
		end else if (count == 2 && prefix == KW_IF) begin
			push_token(KIND_IF, '0, ERR_NONE);
		end else if (count == 4 && prefix == KW_ELSE) begin
			push_token(KIND_ELSE, '0, ERR_NONE);
		end else if (count == 2 && prefix == KW_IS) begin
			push_token(KIND_IS, '0, ERR_NONE);
		end else if (count == 4 && prefix == KW_TRUE) begin
			push_token(KIND_NUM, 32'd1, ERR_NONE);
		end else if (count == 5 && prefix == KW_FALSE) begin
			push_token(KIND_NUM, '0, ERR_NONE);
		end else begin
			push_token(KIND_IDENT, 32'(count), ERR_NONE);
		end
	endtask

	task automatic idle_byte(input logic [7:0] c);
		if (c == " " || c == CH_TAB || c == CH_LF) begin
			return;
		end else if (c >= "0" && c <= "9") begin
			mode  = MODE_NUM;
			accum = 32'(c - "0");
			count = 1;
		end else if (c >= "a" && c <= "z") begin
			mode   = MODE_WORD;
			prefix = {56'd0, c};
			count  = 1;
			push_token(KIND_TEXT, {24'd0, c}, ERR_NONE);
		end else if (c == "\"") begin
			mode  = MODE_STR;
			count = 0;
		end else if (c == ":") begin
			mode = MODE_COLON;
		end else begin
			push_token(operator_kind(c), '0, ERR_NONE);
		end
	endtask

	// Characters past the length cap vanish together with their escape flag
	task automatic store_text(input logic [7:0] c, input logic [1:0] err);
		if (count < TEXT_LEN - 1) begin
			count++;
			push_token(KIND_TEXT, {24'd0, c}, err);
		end
	endtask

	task automatic unterminated();
		mode = MODE_IDLE;
		push_token(KIND_STR, 32'(count), ERR_UNTERM);
		push_token(KIND_END, '0, ERR_NONE);
	endtask

	task automatic advance_lexer(input logic [7:0] c);
		case (mode)
			MODE_NUM: begin
				if (c >= "0" && c <= "9" && count < TEXT_LEN) begin
					accum = accum * 32'd10 + 32'(c - "0");
					count++;
				end else begin
					push_token(KIND_NUM, accum, ERR_NONE);
					mode = MODE_IDLE;
					idle_byte(c);
				end
			end
			MODE_WORD: begin
				if (c >= "a" && c <= "z" && count < TEXT_LEN) begin
					if (count < 8)
						prefix = {prefix[55:0], c};
					count++;
					push_token(KIND_TEXT, {24'd0, c}, ERR_NONE);
				end else begin
					close_word();
					mode = MODE_IDLE;
					idle_byte(c);
				end
			end
			MODE_STR: begin
				if (c == "\"") begin
					mode = MODE_IDLE;
					push_token(KIND_STR, 32'(count), ERR_NONE);
				end else if (c == CH_NUL) begin
					unterminated();
				end else if (c == "\\") begin
					mode = MODE_ESC;
				end else begin
					store_text(c, ERR_NONE);
				end
			end
			MODE_ESC: begin
				if (c == CH_NUL) begin
					unterminated();
				end else begin
					mode = MODE_STR;
					case (c)
						"n":            store_text(CH_LF, ERR_NONE);
						"t":            store_text(CH_TAB, ERR_NONE);
						"r":            store_text(CH_CR, ERR_NONE);
						"\\", "\"", "'": store_text(c, ERR_NONE);
						default:        store_text(c, ERR_ESCAPE);
					endcase
				end
			end
			MODE_COLON: begin
				mode = MODE_IDLE;
				if (c == "=") begin
					push_token(KIND_CREATE, '0, ERR_NONE);
				end else begin
					push_token(KIND_END, '0, ERR_NONE);
					idle_byte(c);
				end
			end
			default: begin
				mode = MODE_IDLE;
				idle_byte(c);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			mode   = MODE_IDLE;
			count  = 0;
			accum  = '0;
			prefix = '0;
			token_queue.delete();
			fail_count  = 0;
			byte_count  = 0;
			token_count = 0;
		end else begin
			// A byte accepted now cannot produce a result at this same edge
			if (token_valid && token_ready) begin
				token_count++;
				if (token_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected kind %0d value %0d error %0d",
						token_kind, $signed(token_value), lex_error));
				end else begin
					want = token_queue.pop_front();
					if (token_kind !== want.kind || token_value !== want.value ||
						lex_error !== want.err)
						report_mismatch($sformatf(
							"got kind %0d value %0d error %0d, want %0d %0d %0d",
							token_kind, $signed(token_value), lex_error,
							want.kind, want.value, want.err));
				end
			end
			if (text_valid && text_ready) begin
				byte_count++;
				advance_lexer(text_byte);
			end
		end
		outstanding <= token_queue.size();
	end

endmodule

### tb/keyword_lexer_tb.sv
// Testbench top: drives text bytes into the keyword lexer and gives the verdict.
`timescale 1ns / 1ps
module keyword_lexer_tb;

	// Bytes to send in the random part, whitespace included
	localparam int RANDOM_BYTES = 1150;
	// Cycles without any transfer on either channel before the run is called hung
	localparam int QUIET_LIMIT  = 2000;
	// Cycles to watch for stray tokens once nothing more is expected
	localparam int SETTLE_CYCLES = 10;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] HIGH_BYTE = 8'hFF;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int idle_pct    = 19;
	int stall_pct   = 19;
	int quiet_count = 0;
	int sent_bytes  = 0;
	int outstanding;
	int fail_count;
	int byte_count;
	int token_count;

	string keyword_list[7] = '{"let", "function", "if", "else", "is", "true", "false"};
	string operator_chars  = "+-*/%<>(){}=;[]";

	kl_text_if  text_ch ();
	kl_token_if token_ch ();

	always #5 clk = ~clk;

	keyword_lexer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	kl_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_ch.valid),
		.text_ready  (text_ch.ready),
		.text_byte   (text_ch.text_byte),
		.token_valid (token_ch.valid),
		.token_ready (token_ch.ready),
		.token_kind  (token_ch.token_kind),
		.token_value (token_ch.token_value),
		.lex_error   (token_ch.lex_error),
		.outstanding (outstanding),
		.fail_count  (fail_count),
		.byte_count  (byte_count),
		.token_count (token_count)
	);

	// Token side: stall at random, at the rate that stall_pct currently holds
	always @(posedge clk) begin
		token_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung block shows up as a long run of cycles with no transfer
	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready)) begin
			quiet_count <= 0;
		end else if (quiet_count >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("FAIL keyword_lexer");
			$finish;
		end else begin
			quiet_count <= quiet_count + 1;
		end
	end

	// Offer one byte and hold it until the transfer. Called at a rising edge,
	// returns at the edge of the transfer; valid stays high for the next byte
	// unless the next call decides to idle first.
	task automatic offer_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_byte <= b;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		offer_byte(b);
		sent_bytes++;
	endtask

	// Whitespace between tokens: skipped by the block
	task automatic send_blank();
		case ($urandom_range(2))
			0:       send_byte(" ");
			1:       send_byte(CH_TAB);
			default: send_byte(CH_LF);
		endcase
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_letters(input int n);
		repeat (n)
			send_byte(8'("a" + $urandom_range(25)));
	endtask

	// Numbers: mostly short, some long enough to wrap, a few past the digit cap
	task automatic send_number();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 12);
		repeat (n)
			send_byte(8'("0" + $urandom_range(9)));
	endtask

	// Words: exact keywords, keywords with extra letters or cut short,
	// random identifiers, and a few past the letter cap
	task automatic send_word();
		string kw;
		kw = keyword_list[$urandom_range(6)];
		case ($urandom_range(9))
			0, 1, 2, 3: send_text(kw);
			4, 5: begin
				send_text(kw);
				send_letters($urandom_range(1, 2));
			end
			6:       send_text(kw.substr(0, kw.len() - 2));
			7, 8:    send_letters($urandom_range(1, 10));
			default: send_letters($urandom_range(30, 34));
		endcase
	endtask

	// Strings: printable text, any other byte, every escape and unknown ones;
	// mostly closed, sometimes cut off by a zero byte, also right after a backslash
	task automatic send_string();
		int          n;
		logic [7:0]  c;
		send_byte("\"");
		n = ($urandom_range(7) == 0) ? $urandom_range(29, 36) : $urandom_range(0, 8);
		repeat (n) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					c = 8'($urandom_range(32, 126));
					if (c == "\"" || c == "\\")
						c = "_";
					send_byte(c);
				end
				6: begin
					c = 8'($urandom_range(1, 255));
					if (c == "\"" || c == "\\")
						c = "_";
					send_byte(c);
				end
				default: begin
					send_byte("\\");
					case ($urandom_range(7))
						0:       send_byte("n");
						1:       send_byte("t");
						2:       send_byte("r");
						3:       send_byte("\\");
						4:       send_byte("\"");
						5:       send_byte("'");
						default: send_byte(8'($urandom_range(1, 255)));
					endcase
				end
			endcase
		end
		case ($urandom_range(9))
			8:       send_byte(CH_NUL);
			9: begin
				send_byte("\\");
				send_byte(CH_NUL);
			end
			default: send_byte("\"");
		endcase
	endtask

	// Drop valid and hold off until every predicted token has arrived
	task automatic wait_for_tokens();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int pick;

		text_ch.valid     = 1'b0;
		text_ch.text_byte = '0;
		token_ch.ready    = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: create, lone colon, every operator, a string with an unknown
		// and a known escape cut off by end of text, a high unknown byte, end of text
		send_text(":=:+-*/%<>(){}=;[]");
		send_text("\"a\\q\\n");
		send_byte(CH_NUL);
		send_byte(HIGH_BYTE);
		send_byte(CH_NUL);

		// Hold the sender back until the block has drained
		wait_for_tokens();

		sent_bytes = 0;
		while (sent_bytes < RANDOM_BYTES) begin
			// Run a stretch with both sides going flat out
			if (sent_bytes >= 400 && sent_bytes < 650) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = 19;
				stall_pct = 19;
			end

			pick = $urandom_range(99);
			if (pick < 10)
				send_blank();
			else if (pick < 26)
				send_number();
			else if (pick < 48)
				send_word();
			else if (pick < 63)
				send_string();
			else if (pick < 75)
				send_byte(operator_chars[$urandom_range(14)]);
			else if (pick < 81) begin
				if ($urandom_range(1) == 0)
					send_text(":=");
				else
					send_text(":");
			end else if (pick < 93)
				send_byte(8'($urandom_range(255)));
			else
				send_byte(CH_NUL);

			// Separate most tokens so well-formed sequences dominate
			if ($urandom_range(3) != 0)
				send_blank();
		end

		// Close whatever token is open, then let the block settle
		send_byte(CH_NUL);
		wait_for_tokens();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d text bytes and checked %0d tokens across numbers, words,",
			byte_count, token_count);
		$display("keywords, strings with escapes and cut-offs, operators and stray bytes.");
		if (fail_count == 0) begin
			$display("PASS keyword_lexer");
		end else begin
			$display("FAIL keyword_lexer");
		end
		$finish;
	end

endmodule
